[hw/rtl/adsr_pkg.sv]
// shared types, codes and constants of the synthesizer voice
package adsr_pkg;

	localparam int RATE_HZ_DEF    = 44100;
	localparam int PHASE_BITS_DEF = 24;

	localparam int STEP_W     = 24;
	localparam int LEN_W      = 19;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 19;
	localparam int SAMPLE_W   = 17;
	localparam int GAIN_W     = 17;

	// shared multiplier operand width
	localparam int MUL_W = 34;

	// envelope divider
	localparam int DIV_NUM_W = 36;
	localparam int DIV_Q_W   = 17;
	localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_PLAY  = 2'd2;
	localparam logic [1:0] CMD_STOP  = 2'd3;

	localparam logic [2:0] REG_WAVE    = 3'd0;
	localparam logic [2:0] REG_VOLUME  = 3'd1;
	localparam logic [2:0] REG_DUTY    = 3'd2;
	localparam logic [2:0] REG_ATTACK  = 3'd3;
	localparam logic [2:0] REG_DECAY   = 3'd4;
	localparam logic [2:0] REG_SUSTAIN = 3'd5;
	localparam logic [2:0] REG_RELEASE = 3'd6;

	localparam logic [2:0] WAVE_SINE  = 3'd0;
	localparam logic [2:0] WAVE_TRI   = 3'd1;
	localparam logic [2:0] WAVE_SQUARE = 3'd2;
	localparam logic [2:0] WAVE_SAW   = 3'd3;
	localparam logic [2:0] WAVE_NOISE = 3'd4;

	localparam logic [2:0] STG_OFF     = 3'd0;
	localparam logic [2:0] STG_ATTACK  = 3'd1;
	localparam logic [2:0] STG_DECAY   = 3'd2;
	localparam logic [2:0] STG_SUSTAIN = 3'd3;
	localparam logic [2:0] STG_RELEASE = 3'd4;

	localparam logic [31:0] LFSR_MASK = 32'h8020_0003;
	localparam logic [31:0] LFSR_SEED = 32'h0000_0001;

	localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

	// polynomial constants of the sine, Q31 scaled
	localparam logic [MUL_W-1:0] SIN_C3 = 34'd41 << 28;
	localparam logic [32:0]      SIN_C1 = 33'd201 << 25;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ENV_MUL,
		ST_DIV_GO,
		ST_SQ_MUL,
		ST_T_CALC,
		ST_T_MUL,
		ST_S_CALC,
		ST_S_MUL,
		ST_R_CAP,
		ST_DIV_WAIT,
		ST_AMP_MUL,
		ST_MAG_LD,
		ST_OUT_MUL,
		ST_FINISH
	} state_t;

endpackage

[hw/rtl/adsr_in_if.sv]
// request channel of the voice: command, phase step and note length
interface adsr_in_if;
	import adsr_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        command;
	logic [STEP_W-1:0] phase_step;
	logic [LEN_W-1:0]  note_length;

	modport source(output valid, output command, output phase_step, output note_length,
		input ready);
	modport sink(input valid, input command, input phase_step, input note_length,
		output ready);
endinterface

[hw/rtl/adsr_out_if.sv]
// sample channel of the voice
interface adsr_out_if;
	import adsr_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_value;
	logic                       is_playing;
	logic [2:0]                 stage_now;

	modport source(output valid, output sample_value, output is_playing, output stage_now,
		input ready);
	modport sink(input valid, input sample_value, input is_playing, input stage_now,
		output ready);
endinterface

[hw/rtl/adsr_div.sv]
// restoring divider for the envelope gain, one quotient bit per cycle
module adsr_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [adsr_pkg::DIV_NUM_W-1:0] num,
	input  logic [adsr_pkg::LEN_W-1:0]     den,
	output logic                          busy,
	output logic [adsr_pkg::DIV_Q_W-1:0]   quo
);
	import adsr_pkg::*;

	logic [LEN_W-1:0]     rem_q;
	logic [DIV_Q_W-1:0]   qn_q;
	logic [LEN_W-1:0]     den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [LEN_W:0]       rem2;
	logic [LEN_W:0]       diff;
	logic                 ge;

	assign rem2 = {rem_q, qn_q[DIV_Q_W-1]};
	assign diff = rem2 - {1'b0, den_q};
	assign ge   = rem2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_Q_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// quotient is known to fit, so the top of the numerator is already below den
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[DIV_NUM_W-1:DIV_Q_W];
			qn_q  <= num[DIV_Q_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[LEN_W-1:0] : rem2[LEN_W-1:0];
			qn_q  <= {qn_q[DIV_Q_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = qn_q;
endmodule

[hw/rtl/adsr_waveform_oscillator_unit.sv]
// synthesizer voice: phase accumulator, adsr envelope and waveform sample
//
//  channel  | dir | payload                                   | handshake
//  in_ch    | in  | command, phase_step, note_length          | valid/ready
//  out_ch   | out | sample_value, is_playing, stage_now       | valid/ready
//  cfg      | in  | cfg_index, cfg_data                       | cfg_we
//
// start note, play and stop give no sample.
// a tick runs the gain divider alongside the sine polynomial on the one shared
// 34x34 multiplier, then two more products.
// reset clears all control state; no clearing pass is needed.
// a finished sample waits in the output register; a new request is taken
// meanwhile, and the next tick holds in its last step until the slot is free.
module adsr_waveform_oscillator_unit #(
	parameter int RATE_HZ    = adsr_pkg::RATE_HZ_DEF,
	parameter int PHASE_BITS = adsr_pkg::PHASE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [adsr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [adsr_pkg::CFG_DATA_W-1:0] cfg_data,
	adsr_in_if.sink                         in_ch,
	adsr_out_if.source                      out_ch
);
	import adsr_pkg::*;

	localparam int SW = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;
	localparam logic [SW:0] ONE_W = 1;
	localparam logic [SW:0] TURN  = ONE_W << PHASE_BITS;
	localparam longint unsigned STEP_FULL =
		((64'd1000 << PHASE_BITS) + RATE_HZ / 2) / RATE_HZ;
	localparam logic [SW-1:0] STEP_RST = STEP_FULL[SW-1:0];

	// configuration
	logic [2:0]       wave_q;
	logic [7:0]       vol_q;
	logic [9:0]       duty_q;
	logic [LEN_W-1:0] att_q, dec_q, rel_q;
	logic [8:0]       sus_q;

	// voice state
	logic [PHASE_BITS-1:0] phase_q;
	logic [SW-1:0]         step_q;
	logic [2:0]            stage_q;
	logic [LEN_W-1:0]      count_q;
	logic [LEN_W-1:0]      hold_q;
	logic                  play_q;
	logic [31:0]           lfsr_q;

	// shared multiplier and work registers
	logic [MUL_W-1:0]   a_q, b_q;
	logic [2*MUL_W-1:0] p_q;
	logic [30:0]        m_q;
	logic               sneg_q;
	logic [31:0]        r_q;
	logic               wneg_q;

	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       oplay_q;
	logic [2:0]                 ostage_q;

	state_t state_q, state_nx;

	logic in_fire, div_start, div_busy, fin_take;
	logic [DIV_Q_W-1:0] quo;

	// ---------------- combinational datapath ----------------
	logic [LEN_W-1:0]      len_c, cc_c;
	logic                  stage_act;
	logic [GAIN_W-1:0]     fac_c, gain_c;
	logic [SW:0]           psum;
	logic [PHASE_BITS-1:0] phase_nx;
	logic [31:0]           ph32;
	logic [32:0]           ksum;
	logic [1:0]            k_c;
	logic signed [33:0]    y_c, ya_c;
	logic [30:0]           m_c;
	logic [29:0]           y2_c;
	logic [MUL_W-1:0]      nine_c, t_c;
	logic [32:0]           s_c;
	logic [31:0]           lfsr_sh, lfsr_nx;
	logic signed [33:0]    w_c, wa_c;
	logic [31:0]           mag_c;
	logic                  neg_c;
	logic [SAMPLE_W-1:0]   qv_c;

	always_comb begin
		unique case (stage_q)
			STG_ATTACK:  len_c = att_q;
			STG_DECAY:   len_c = dec_q;
			STG_SUSTAIN: len_c = hold_q;
			STG_RELEASE: len_c = rel_q;
			default:     len_c = '0;
		endcase
	end

	assign stage_act = (stage_q >= STG_ATTACK) && (stage_q <= STG_RELEASE);
	assign cc_c      = (count_q > len_c) ? len_c : count_q;

	always_comb begin
		unique case (stage_q)
			STG_ATTACK:  fac_c = GAIN_ONE;
			STG_DECAY:   fac_c = {9'd256 - sus_q, 8'd0};
			STG_RELEASE: fac_c = {sus_q, 8'd0};
			default:     fac_c = '0;
		endcase
	end

	always_comb begin
		if (!stage_act) begin
			gain_c = GAIN_ONE;
		end else if (stage_q == STG_SUSTAIN) begin
			gain_c = {sus_q, 8'd0};
		end else if (len_c == '0) begin
			gain_c = GAIN_ONE;
		end else if (stage_q == STG_ATTACK) begin
			gain_c = quo;
		end else if (stage_q == STG_DECAY) begin
			gain_c = GAIN_ONE - quo;
		end else begin
			gain_c = {sus_q, 8'd0} - quo;
		end
	end

	// phase goes to zero on reaching a full turn
	assign psum     = {1'b0, step_q} + (SW + 1)'(phase_q);
	assign phase_nx = (psum >= TURN) ? '0 : psum[PHASE_BITS-1:0];
	assign ph32     = 32'(phase_q) << (32 - PHASE_BITS);

	// sine argument folded to [-1/2, 1/2)
	assign ksum = {1'b0, ph32} + 33'h0_4000_0000;
	assign k_c  = ksum[32:31];
	assign y_c  = $signed({2'b00, ph32}) - $signed({1'b0, k_c, 31'd0});
	assign ya_c = y_c[33] ? -y_c : y_c;
	assign m_c  = ya_c[30:0];

	assign y2_c   = p_q[60:31];
	assign nine_c = {1'b0, y2_c, 3'd0} + MUL_W'(y2_c);
	assign t_c    = SIN_C3 - (nine_c >> 2);
	assign s_c    = SIN_C1 - p_q[63:31];

	assign lfsr_sh = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_MASK) : (lfsr_q >> 1);
	assign lfsr_nx = (lfsr_sh == '0) ? LFSR_SEED : lfsr_sh;

	always_comb begin
		unique case (wave_q)
			WAVE_TRI: begin
				if (!ph32[31]) begin
					w_c = $signed({2'b00, ph32}) - 34'sd1073741824;
				end else begin
					w_c = 34'sd3221225472 - $signed({2'b00, ph32});
				end
			end
			WAVE_SQUARE: w_c = (ph32 > {duty_q, 22'd0}) ? 34'sd1073741824 : -34'sd1073741824;
			WAVE_SAW:    w_c = $signed({2'b00, ph32}) - 34'sd2147483648;
			WAVE_NOISE:  w_c = $signed({2'b00, lfsr_nx}) - 34'sd2147483648;
			default:     w_c = '0;
		endcase
	end

	assign wa_c = w_c[33] ? -w_c : w_c;

	always_comb begin
		if (wave_q == WAVE_SINE) begin
			mag_c = r_q;
			neg_c = sneg_q;
		end else begin
			mag_c = wa_c[31:0];
			neg_c = w_c[33];
		end
	end

	assign qv_c = p_q[55:39];

	// ---------------- sequencer ----------------
	assign in_fire = in_ch.valid && in_ch.ready;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_fire && in_ch.command == CMD_TICK) state_nx = ST_ENV_MUL;
			ST_ENV_MUL:  state_nx = ST_DIV_GO;
			ST_DIV_GO:   state_nx = ST_SQ_MUL;
			ST_SQ_MUL:   state_nx = ST_T_CALC;
			ST_T_CALC:   state_nx = ST_T_MUL;
			ST_T_MUL:    state_nx = ST_S_CALC;
			ST_S_CALC:   state_nx = ST_S_MUL;
			ST_S_MUL:    state_nx = ST_R_CAP;
			ST_R_CAP:    state_nx = ST_DIV_WAIT;
			ST_DIV_WAIT: if (!div_busy) state_nx = ST_AMP_MUL;
			ST_AMP_MUL:  state_nx = ST_MAG_LD;
			ST_MAG_LD:   state_nx = ST_OUT_MUL;
			ST_OUT_MUL:  state_nx = ST_FINISH;
			ST_FINISH:   if (fin_take) state_nx = ST_IDLE;
			default:     state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = (state_q == ST_IDLE);
		div_start   = (state_q == ST_DIV_GO);
		fin_take    = (state_q == ST_FINISH) && (!out_valid_q || out_ch.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	adsr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (p_q[DIV_NUM_W-1:0]),
		.den    (len_c),
		.busy   (div_busy),
		.quo    (quo)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q <= WAVE_SINE;
			vol_q  <= '0;
			duty_q <= 10'd512;
			att_q  <= '0;
			dec_q  <= '0;
			sus_q  <= '0;
			rel_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WAVE:    wave_q <= cfg_data[2:0];
				REG_VOLUME:  vol_q  <= cfg_data[7:0];
				REG_DUTY:    duty_q <= (cfg_data[9:0] == '0) ? 10'd1 : cfg_data[9:0];
				REG_ATTACK:  att_q  <= cfg_data;
				REG_DECAY:   dec_q  <= cfg_data;
				REG_SUSTAIN: sus_q  <= (cfg_data[8:0] > 9'd256) ? 9'd256 : cfg_data[8:0];
				REG_RELEASE: rel_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// voice state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			step_q  <= STEP_RST;
			stage_q <= STG_OFF;
			count_q <= '0;
			hold_q  <= '0;
			play_q  <= 1'b0;
			lfsr_q  <= LFSR_SEED;
		end else if (in_fire) begin
			unique case (in_ch.command)
				CMD_TICK: phase_q <= phase_nx;
				CMD_START: begin
					count_q <= '0;
					step_q  <= SW'(in_ch.phase_step);
					stage_q <= STG_ATTACK;
					hold_q  <= in_ch.note_length;
					play_q  <= 1'b1;
				end
				CMD_PLAY: begin
					step_q <= SW'(in_ch.phase_step);
					play_q <= 1'b1;
				end
				default: play_q <= 1'b0;
			endcase
		end else if (fin_take) begin
			if (wave_q == WAVE_NOISE) begin
				lfsr_q <= lfsr_nx;
			end
			if (stage_act) begin
				if (({1'b0, count_q} + 1'b1) >= {1'b0, len_c}) begin
					count_q <= '0;
					if (stage_q == STG_RELEASE) begin
						stage_q <= STG_OFF;
						play_q  <= 1'b0;
					end else begin
						stage_q <= stage_q + 1'b1;
					end
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// operand loads and work registers
	always_ff @(posedge clk) begin
		p_q <= a_q * b_q;
		unique case (state_q)
			ST_IDLE: begin
				a_q <= MUL_W'(cc_c);
				b_q <= MUL_W'(fac_c);
			end
			ST_DIV_GO: begin
				a_q    <= MUL_W'(m_c);
				b_q    <= MUL_W'(m_c);
				m_q    <= m_c;
				sneg_q <= y_c[33] ^ k_c[0];
			end
			ST_T_CALC: begin
				a_q <= t_c;
				b_q <= MUL_W'(y2_c);
			end
			ST_S_CALC: begin
				a_q <= MUL_W'(m_q);
				b_q <= MUL_W'(s_c);
			end
			ST_R_CAP: r_q <= p_q[62:31];
			ST_DIV_WAIT: begin
				a_q <= MUL_W'(vol_q);
				b_q <= MUL_W'(gain_c);
			end
			ST_MAG_LD: begin
				a_q    <= MUL_W'(mag_c);
				b_q    <= p_q[MUL_W-1:0];
				wneg_q <= neg_c;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// stage and flag reflect the state after this tick
	always_ff @(posedge clk) begin
		if (fin_take) begin
			sample_q <= wneg_q ? -$signed(qv_c) : $signed(qv_c);
			if (stage_act && (({1'b0, count_q} + 1'b1) >= {1'b0, len_c})) begin
				ostage_q <= (stage_q == STG_RELEASE) ? STG_OFF : stage_q + 1'b1;
				oplay_q  <= (stage_q == STG_RELEASE) ? 1'b0 : play_q;
			end else begin
				ostage_q <= stage_q;
				oplay_q  <= play_q;
			end
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.sample_value = sample_q;
	assign out_ch.is_playing   = oplay_q;
	assign out_ch.stage_now    = ostage_q;

	a_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_ch.command == CMD_TICK) |=> state_q == ST_ENV_MUL)
		else $error("tick did not start the sequence");

	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FINISH)
		else $error("sample shown outside the last step");

	a_release_end: assert property (@(posedge clk) disable iff (!arst_n)
		($past(stage_q) == STG_RELEASE && stage_q == STG_OFF) |-> !play_q)
		else $error("release ended with voice still playing");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_AMP_MUL) |-> !div_busy)
		else $error("gain used before the divider finished");
endmodule

[tb/adsr_waveform_oscillator_unit_tb.sv]
// testbench of the synthesizer voice: random and directed requests, checked against a predictor
`timescale 1ns / 100ps

module adsr_waveform_oscillator_unit_tb;
	import adsr_pkg::*;

	localparam longint unsigned TURN = 64'd1 << PHASE_BITS_DEF;

	typedef struct {
		logic [SAMPLE_W-1:0] sample;
		logic                playing;
		logic [2:0]          stage;
	} sample_t;

	class voice_scoreboard;
		longint unsigned wave, volume, duty, attack_len, decay_len, sustain, release_len;
		longint unsigned phase, step, count, hold_len, lfsr;
		logic [2:0]      stage;
		bit              playing;
		sample_t         pending[$];
		int              errors;

		function new();
			wave = WAVE_SINE; volume = 0; duty = 512;
			attack_len = 0; decay_len = 0; sustain = 0; release_len = 0;
			phase = 0;
			step = (64'd1000 * TURN + RATE_HZ_DEF / 2) / RATE_HZ_DEF;
			stage = STG_OFF; count = 0; hold_len = 0; playing = 0; lfsr = 1;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, longint unsigned val);
			case (idx)
				REG_WAVE: wave = val & 7;
				REG_VOLUME: volume = val & 8'hff;
				REG_DUTY: begin
					duty = val & 10'h3ff;
					if (duty < 1) duty = 1;
				end
				REG_ATTACK: attack_len = val & 19'h7ffff;
				REG_DECAY: decay_len = val & 19'h7ffff;
				REG_SUSTAIN: begin
					sustain = val & 9'h1ff;
					if (sustain > 256) sustain = 256;
				end
				REG_RELEASE: release_len = val & 19'h7ffff;
				default: ;
			endcase
		endfunction

		function longint unsigned envelope_gain(longint unsigned len);
			longint unsigned c;
			c = count;
			if (stage < STG_ATTACK || stage > STG_RELEASE) return 65536;
			if (stage == STG_SUSTAIN) return sustain << 8;
			if (len == 0) return 65536;
			if (c > len) c = len;
			if (stage == STG_ATTACK) return (c << 16) / len;
			if (stage == STG_DECAY) return 65536 - ((c * (256 - sustain)) << 8) / len;
			return (sustain << 8) - ((sustain * c) << 8) / len;
		endfunction

		function longint sine_wave(longint unsigned ph);
			longint unsigned k, m, y2, t, s;
			longint          y, r;
			k = (ph + (64'd1 << 30)) >> 31;
			y = longint'(ph) - longint'(k << 31);
			m = y < 0 ? -y : y;
			y2 = (m * m) >> 31;
			t = (64'd41 << 28) - (9 * y2) / 4;
			s = (64'd201 << 25) - ((t * y2) >> 31);
			r = longint'((m * s) >> 31);
			return ((y < 0) != k[0]) ? -r : r;
		endfunction

		function longint wave_value(longint unsigned ph);
			case (wave)
				WAVE_SINE: return sine_wave(ph);
				WAVE_TRI: begin
					if (ph < (64'd1 << 31)) return longint'(ph) - (64'sd1 << 30);
					return (64'sd3 << 30) - longint'(ph);
				end
				WAVE_SQUARE: return ph > (duty << 22) ? (64'sd1 << 30) : -(64'sd1 << 30);
				WAVE_SAW: return longint'(ph) - (64'sd1 << 31);
				WAVE_NOISE: begin
					if (lfsr[0]) lfsr = (lfsr >> 1) ^ LFSR_MASK;
					else lfsr = lfsr >> 1;
					if (lfsr == 0) lfsr = 1;
					return longint'(lfsr) - (64'sd1 << 31);
				end
				default: return 0;
			endcase
		endfunction

		function void note_request(logic [1:0] cmd, longint unsigned pstep, longint unsigned nlen);
			longint unsigned len, gain, mag, q;
			longint          w, v;
			sample_t         e;
			case (cmd)
				CMD_START: begin
					count = 0; step = pstep; stage = STG_ATTACK; hold_len = nlen; playing = 1;
				end
				CMD_PLAY: begin
					step = pstep; playing = 1;
				end
				CMD_STOP: playing = 0;
				default: begin
					phase = phase + step;
					if (phase >= TURN) phase = 0;
					case (stage)
						STG_ATTACK: len = attack_len;
						STG_DECAY: len = decay_len;
						STG_SUSTAIN: len = hold_len;
						STG_RELEASE: len = release_len;
						default: len = 0;
					endcase
					gain = envelope_gain(len);
					if (stage >= STG_ATTACK && stage <= STG_RELEASE) begin
						if (count + 1 >= len) begin
							count = 0;
							if (stage == STG_RELEASE) begin
								stage = STG_OFF; playing = 0;
							end else stage = stage + 1;
						end else count++;
					end
					w = wave_value(phase << (32 - PHASE_BITS_DEF));
					mag = w < 0 ? -w : w;
					q = (mag * (volume * gain)) >> 39;
					v = w < 0 ? -longint'(q) : longint'(q);
					e.sample = v[SAMPLE_W-1:0];
					e.playing = playing;
					e.stage = stage;
					pending.push_back(e);
				end
			endcase
		endfunction

		function void check_sample(logic [SAMPLE_W-1:0] smp, logic pl, logic [2:0] stg);
			sample_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected sample %h playing %b stage %0d", $time, smp, pl, stg);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (smp !== e.sample) begin
				$display("%0t: sample_value expected %h actual %h", $time, e.sample, smp);
				errors++;
			end
			if (pl !== e.playing) begin
				$display("%0t: is_playing expected %b actual %b", $time, e.playing, pl);
				errors++;
			end
			if (stg !== e.stage) begin
				$display("%0t: stage_now expected %0d actual %0d", $time, e.stage, stg);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	adsr_in_if  in_ch();
	adsr_out_if out_ch();

	adsr_waveform_oscillator_unit u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	voice_scoreboard sb = new();
	bit calm;
	int hold_off_req;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

	always @(posedge clk)
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_sample(out_ch.sample_value, out_ch.is_playing, out_ch.stage_now);

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		int burst, hold_cnt;
		burst = 0; hold_cnt = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req > 0) begin
				hold_cnt = hold_off_req;
				hold_off_req = 0;
			end
			if (hold_cnt > 0) begin
				out_ch.ready = 1'b0;
				hold_cnt--;
			end else if (calm) out_ch.ready = 1'b1;
			else if (burst > 0) begin
				out_ch.ready = 1'b0;
				burst--;
			end else begin
				out_ch.ready = 1'b1;
				if ($urandom_range(0, 4) == 0) burst = $urandom_range(1, 4);
			end
		end
	end

	task automatic send(logic [1:0] cmd, logic [STEP_W-1:0] pstep, logic [LEN_W-1:0] nlen);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_ch.valid = 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.command = cmd;
		in_ch.phase_step = pstep;
		in_ch.note_length = nlen;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_request(cmd, pstep, nlen);
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.write_reg(idx, val);
	endtask

	// wait for every outstanding sample, then let the datapath settle
	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_reg(logic [2:0] idx);
		int sel;
		sel = $urandom_range(0, 9);
		case (idx)
			REG_WAVE: return $urandom_range(0, 7);
			REG_VOLUME: return sel == 0 ? 0 : sel == 1 ? 255 : sel < 5 ? 128 : $urandom_range(0, 255);
			REG_DUTY: return sel == 0 ? 0 : sel == 1 ? 1023 : $urandom_range(0, 1023);
			REG_SUSTAIN: return sel == 0 ? 0 : sel == 1 ? 256 : sel == 2 ? 511 : $urandom_range(0, 511);
			default: return sel == 0 ? 0 : sel == 1 ? 19'h7ffff : sel == 2 ? $urandom() : $urandom_range(0, 8);
		endcase
	endfunction

	function automatic logic [STEP_W-1:0] pick_step();
		int sel;
		sel = $urandom_range(0, 9);
		return sel == 0 ? 0 : sel == 1 ? 24'h800000 : sel == 2 ? 24'hffffff : $urandom();
	endfunction

	function automatic logic [LEN_W-1:0] pick_len();
		int sel;
		sel = $urandom_range(0, 9);
		return sel == 0 ? 19'h7ffff : sel == 1 ? $urandom() : $urandom_range(0, 10);
	endfunction

	task automatic random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 72) send(CMD_TICK, $urandom(), $urandom());
		else if (r < 84) send(CMD_START, pick_step(), pick_len());
		else if (r < 93) send(CMD_PLAY, pick_step(), $urandom());
		else send(CMD_STOP, $urandom(), $urandom());
	endtask

	initial begin
		int ph, i, w;
		calm = 1'b0;
		hold_off_req = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.command = CMD_TICK;
		in_ch.phase_step = '0;
		in_ch.note_length = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: tick at reset defaults, then a short note through all stages
		send(CMD_TICK, 0, 0);
		drain();
		write_reg(REG_VOLUME, 128);
		write_reg(REG_ATTACK, 2);
		write_reg(REG_DECAY, 2);
		write_reg(REG_SUSTAIN, 511);
		write_reg(REG_RELEASE, 0);
		write_reg(REG_DUTY, 0);
		send(CMD_START, 24'h800000, 1);
		for (i = 0; i < 6; i++) send(CMD_TICK, 0, 0);
		send(CMD_PLAY, 24'hffffff, 0);
		send(CMD_TICK, 0, 0);
		send(CMD_STOP, 0, 0);
		send(CMD_START, 24'h155555, 19'h7ffff);
		send(CMD_TICK, 0, 0);
		drain();
		// shortened attack while mid-stage, and each waveform
		write_reg(REG_ATTACK, 19'h7ffff);
		send(CMD_START, 24'h0a0000, 0);
		send(CMD_TICK, 0, 0);
		send(CMD_TICK, 0, 0);
		drain();
		write_reg(REG_ATTACK, 1);
		write_reg(REG_DUTY, 1023);
		for (w = 0; w < 8; w++) begin
			drain();
			write_reg(REG_WAVE, CFG_DATA_W'(w));
			send(CMD_TICK, 0, 0);
		end
		drain();

		for (ph = 0; ph < 40; ph++) begin
			if (ph >= 36) calm = 1'b1;
			for (i = 0; i < 7; i++)
				if (ph == 0 || $urandom_range(0, 2) == 0) write_reg(3'(i), pick_reg(3'(i)));
			if (ph == 5) hold_off_req = 300;
			for (i = 0; i < 22; i++) begin
				// well-formed note now and then: start followed by a run of ticks
				if ($urandom_range(0, 7) == 0) begin
					send(CMD_START, pick_step(), $urandom_range(0, 6));
					repeat ($urandom_range(4, 14)) send(CMD_TICK, $urandom(), $urandom());
				end else random_item();
			end
			drain();
		end

		while (sb.pending.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule
